### rtl/core/cdq_pkg.sv
`timescale 1ns / 1ps
// cdq_pkg: shared codes and widths for the circular deque.
// Used by cdq_ctrl and circular_deque_top; depends on nothing.
package cdq_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

### rtl/core/cdq_ram.sv
`timescale 1ns / 1ps
// cdq_ram: generic single-port RAM with registered read data.
// No dependencies.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

### rtl/core/cdq_ctrl.sv
`timescale 1ns / 1ps
// cdq_ctrl: command sequencer, ring pointers and result register of the deque.
// Depends on cdq_pkg; drives the port of one cdq_ram instance.
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   data,
    output logic                       last,
    output logic                       ram_we,
    output logic                       ram_re,
    output logic [IDX_W-1:0]           ram_addr,
    output logic [DATA_W-1:0]          ram_wdata,
    input  logic [DATA_W-1:0]          ram_rdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POP  = 3'b010,
        ST_DUMP = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      front_reg, front_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic                  done_reg, done_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic                  last_reg, last_next;

    logic [IDX_W-1:0]      offset;
    logic [IDX_W:0]        ring_sum;
    logic [IDX_W-1:0]      front_plus1;

    assign busy = (state_reg != ST_IDLE);

    // offset from the front entry of the access in this cycle
    always_comb
    begin
        offset = '0;
        case (state_reg)
            ST_DUMP:
            begin
                offset = idx_reg[IDX_W-1:0];
            end
            ST_IDLE:
            begin
                case (kind)
                    KIND_PUSH_FRONT: offset = LAST_IDX;
                    KIND_PUSH_BACK:  offset = count_reg[IDX_W-1:0];
                    KIND_POP_BACK:   offset = count_reg[IDX_W-1:0] - 1'b1;
                    default:         offset = '0;
                endcase
            end
            default:
            begin
                offset = '0;
            end
        endcase
    end

    assign ring_sum  = {1'b0, front_reg} + {1'b0, offset};
    assign ram_addr  = (ring_sum >= DEPTH_SUM) ? IDX_W'(ring_sum - DEPTH_SUM)
                                               : ring_sum[IDX_W-1:0];
    assign front_plus1 = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign ram_wdata = $unsigned(value);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        status_next = STATUS_OK;
        data_next   = '0;
        last_next   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            last_next = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (kind == KIND_PUSH_FRONT)
                                begin
                                    front_next = ram_addr;
                                end
                            end
                        end
                        KIND_POP_FRONT, KIND_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_POP;
                                if (kind == KIND_POP_FRONT)
                                begin
                                    front_next = front_plus1;
                                end
                            end
                        end
                        KIND_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                last_next   = 1'b1;
                                status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                idx_next   = CNT_W'(1);
                                state_next = ST_DUMP;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                done_next  = 1'b1;
                last_next  = 1'b1;
                data_next  = $signed(ram_rdata);
                state_next = ST_IDLE;
            end
            ST_DUMP:
            begin
                done_next = 1'b1;
                data_next = $signed(ram_rdata);
                if (idx_reg == count_reg)
                begin
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        last_reg   <= last_next;
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign last   = last_reg;

endmodule

### rtl/core/circular_deque_top.sv
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words held in a ring RAM.
// Depends on cdq_pkg, cdq_ctrl and cdq_ram.
//
// A command is taken when start is high and busy is low. Every result appears
// for one cycle with done high and must be captured then; the block never waits
// for the receiver. A push, and any command that meets a full or empty queue,
// answers in the cycle after the transfer with busy staying low. A pop answers
// once the word has passed the RAM read register and then the result register,
// busy high for one cycle. A dump of N entries gives N results, one result per
// cycle, with busy high while they are read out; last marks the final result of
// each command. Unused command codes give no result.
module circular_deque_top
    import cdq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [KIND_W-1:0]          kind,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       done,
    output logic [STATUS_W-1:0]        status,
    output logic signed [DATA_W-1:0]   data,
    output logic                       last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              ram_we;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_addr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .value     (value),
        .done      (done),
        .status    (status),
        .data      (data),
        .last      (last),
        .ram_we    (ram_we),
        .ram_re    (ram_re),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata)
    );

    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

endmodule
